### design/iq_packet_deframer_seq_check_macros.svh
// Assertion macros for the deframer checker.
`ifndef IQ_PACKET_DEFRAMER_SEQ_CHECK_MACROS_SVH
`define IQ_PACKET_DEFRAMER_SEQ_CHECK_MACROS_SVH

// Checked at every edge outside of reset.
`define IQDF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define IQDF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/iqdf_pkg.sv
package iqdf_pkg;

   // result kinds
   localparam logic [2:0] KIND_IN_ORDER = 3'd0;
   localparam logic [2:0] KIND_GAP      = 3'd1;
   localparam logic [2:0] KIND_STALE    = 3'd2;
   localparam logic [2:0] KIND_SAMPLE   = 3'd3;
   localparam logic [2:0] KIND_REJECT   = 3'd4;

   localparam logic [7:0] MAGIC0   = 8'h44;  // 'D'
   localparam logic [7:0] MAGIC1   = 8'h52;  // 'R'
   localparam logic [2:0] HDR_LAST = 3'd7;   // header is 8 bytes
   localparam logic [2:0] SMP_LAST = 3'd5;   // sample is 6 bytes

   localparam int RSP_DATA_W = 112;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [15:0]        seq_number;
      logic signed [31:0] i_value;
      logic signed [31:0] q_value;
      logic [31:0]        missed_total;
   } rsp_word_type;

endpackage

### design/iqdf_in_reg.sv
module iqdf_in_reg
   import iqdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_word_type req_word,
   input  logic         take,
   output logic         word_valid,
   output req_word_type word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

### design/iqdf_parser.sv
module iqdf_parser
   import iqdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_word_type word,
   input  logic         step,
   output logic         res_valid,
   output rsp_word_type res
);

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_SAMPLES = 2'd1,
      MODE_DISCARD = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [2:0]  hdr_pos_ff, hdr_pos_in;
   logic [15:0] exp_seq_ff, exp_seq_in;
   logic        seq_known_ff, seq_known_in;
   logic [15:0] cur_seq_ff, cur_seq_in;
   logic [15:0] limit_ff, limit_in;
   logic [7:0]  gain_ff, gain_in;
   logic [15:0] smp_idx_ff, smp_idx_in;
   logic [2:0]  byte_pos_ff, byte_pos_in;
   logic [39:0] partial_ff, partial_in;
   logic [31:0] missed_ff, missed_in;

   logic [7:0]  b;
   logic [47:0] full;
   logic        stale;
   logic [15:0] next_seq;

   // 24-bit sample as Q23, times the gain when it is above one
   function automatic logic signed [31:0] scale24(input logic [23:0] raw,
                                                  input logic [7:0] gain);
      logic signed [31:0] sx;
      logic signed [31:0] gx;
      sx = {{8{raw[23]}}, raw};
      gx = {24'd0, gain};
      if (gain > 8'd1) begin
         scale24 = sx * gx;
      end else begin
         scale24 = sx;
      end
   endfunction

   assign b    = word.data_byte;
   assign full = {partial_ff, b};

   // seq + 2, with the odd wrap: 0xFFFE goes to 1 and 0xFFFF goes to 0
   always_comb begin
      if (cur_seq_ff == 16'hFFFE) begin
         next_seq = 16'd1;
      end else if (cur_seq_ff == 16'hFFFF) begin
         next_seq = 16'd0;
      end else begin
         next_seq = cur_seq_ff + 16'd2;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      hdr_pos_in   = hdr_pos_ff;
      exp_seq_in   = exp_seq_ff;
      seq_known_in = seq_known_ff;
      cur_seq_in   = cur_seq_ff;
      limit_in     = limit_ff;
      gain_in      = gain_ff;
      smp_idx_in   = smp_idx_ff;
      byte_pos_in  = byte_pos_ff;
      partial_in   = partial_ff;
      missed_in    = missed_ff;
      stale        = 1'b0;
      res_valid    = 1'b0;
      res          = '0;

      unique case (mode_ff)
         MODE_HEADER: begin
            if ((hdr_pos_ff == 3'd0 && b != MAGIC0) ||
                (hdr_pos_ff == 3'd1 && b != MAGIC1)) begin
               res_valid = 1'b1;
               res.kind  = KIND_REJECT;
               mode_in   = MODE_DISCARD;
            end else if (hdr_pos_ff == HDR_LAST) begin
               res.kind = KIND_IN_ORDER;
               if (seq_known_ff && cur_seq_ff != exp_seq_ff) begin
                  missed_in = missed_ff + 32'd1;
                  stale     = (cur_seq_ff < exp_seq_ff) && (cur_seq_ff[0] == exp_seq_ff[0]);
                  res.kind  = stale ? KIND_STALE : KIND_GAP;
               end
               if (!stale) begin
                  exp_seq_in   = next_seq;
                  seq_known_in = 1'b1;
                  mode_in      = MODE_SAMPLES;
                  smp_idx_in   = '0;
                  byte_pos_in  = '0;
                  partial_in   = '0;
               end else begin
                  mode_in = MODE_DISCARD;
               end
               res_valid      = 1'b1;
               res.seq_number = cur_seq_ff;
            end else begin
               case (hdr_pos_ff)
                  3'd2:    cur_seq_in = {cur_seq_ff[15:8], b};
                  3'd3:    cur_seq_in = {b, cur_seq_ff[7:0]};
                  3'd4:    limit_in   = {limit_ff[15:8], b};
                  3'd5:    limit_in   = {b, limit_ff[7:0]};
                  3'd6:    gain_in    = b;
                  default: ;
               endcase
               hdr_pos_in = hdr_pos_ff + 3'd1;
               if (word.end_of_packet) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_REJECT;
               end
            end
         end
         MODE_SAMPLES: begin
            if (smp_idx_ff < limit_ff) begin
               if (byte_pos_ff >= SMP_LAST) begin
                  res_valid      = 1'b1;
                  res.kind       = KIND_SAMPLE;
                  res.seq_number = cur_seq_ff;
                  res.i_value    = scale24(full[47:24], gain_ff);
                  res.q_value    = scale24(full[23:0], gain_ff);
                  smp_idx_in     = smp_idx_ff + 16'd1;
                  byte_pos_in    = '0;
                  partial_in     = '0;
               end else begin
                  partial_in  = {partial_ff[31:0], b};
                  byte_pos_in = byte_pos_ff + 3'd1;
               end
            end
         end
         MODE_DISCARD: ;
         default: ;
      endcase

      if (word.end_of_packet) begin
         mode_in     = MODE_HEADER;
         hdr_pos_in  = '0;
         smp_idx_in  = '0;
         byte_pos_in = '0;
         partial_in  = '0;
      end

      res.missed_total = missed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HEADER;
         hdr_pos_ff   <= '0;
         exp_seq_ff   <= '0;
         seq_known_ff <= 1'b0;
         cur_seq_ff   <= '0;
         limit_ff     <= '0;
         gain_ff      <= '0;
         smp_idx_ff   <= '0;
         byte_pos_ff  <= '0;
         partial_ff   <= '0;
         missed_ff    <= '0;
      end else if (step) begin
         mode_ff      <= mode_in;
         hdr_pos_ff   <= hdr_pos_in;
         exp_seq_ff   <= exp_seq_in;
         seq_known_ff <= seq_known_in;
         cur_seq_ff   <= cur_seq_in;
         limit_ff     <= limit_in;
         gain_ff      <= gain_in;
         smp_idx_ff   <= smp_idx_in;
         byte_pos_ff  <= byte_pos_in;
         partial_ff   <= partial_in;
         missed_ff    <= missed_in;
      end
   end

endmodule

### design/iqdf_out_reg.sv
module iqdf_out_reg
   import iqdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type word,
   output logic         can_load,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_word_type rsp_word
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_word   = word_ff;

endmodule

### design/iq_packet_deframer_seq_check.sv
// Channel | Dir | Word contents
// --------+-----+-------------------------------------------------------------
// req_    | in  | tdata[7:0] packet byte, tlast = last byte of the packet
// rsp_    | out | tuser[2:0] kind; tdata = seq, I, Q, missed count (see ports)
//
// One byte per clock, sustained while the result side is not stalled. A byte
// is captured in the input register, parsed in one pass of combinational
// logic and its result (if any) lands in the result register.
// Reset is synchronous; no clearing pass follows.
// A stalled result only holds back a byte that makes a result of its own;
// bytes that make none keep flowing through the parser.
module iq_packet_deframer_seq_check
   import iqdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_packet
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] seq_number, [47:16] i_value, [79:48] q_value, [111:80] missed_total
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser    // [2:0] kind
);

   req_word_type req_word;
   req_word_type word;
   logic         word_valid;
   logic         res_valid;
   rsp_word_type res;
   rsp_word_type rsp_word;
   logic         can_load;
   logic         advance;
   logic         load;

   assign req_word.data_byte     = req_tdata;
   assign req_word.end_of_packet = req_tlast;

   // Held byte moves on when it makes no result or the result register
   // has room for what it makes.
   assign advance = word_valid && (!res_valid || can_load);
   assign load    = advance && res_valid;

   iqdf_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_word   (req_word),
      .take       (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   // Header parse, sequence check and sample unpack/scale.
   iqdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .word      (word),
      .step      (advance),
      .res_valid (res_valid),
      .res       (res)
   );

   iqdf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .word       (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tuser = rsp_word.kind;
   assign rsp_tdata = {rsp_word.missed_total, rsp_word.q_value,
                       rsp_word.i_value, rsp_word.seq_number};

endmodule

### design/iqdf_checker.sv
`include "iq_packet_deframer_seq_check_macros.svh"

module iqdf_checker
   import iqdf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [7:0]            req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]            rsp_tuser
);

   // a stalled result word holds
   `IQDF_ASSERT(a_rsp_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "result word changed while stalled")

   // with the result side empty the block always takes a byte
   `IQDF_ASSERT(a_req_open, !rsp_tvalid |-> req_tready,
      "input blocked with empty result register")

   // only sample words carry I/Q
   `IQDF_ASSERT(a_iq_zero,
      rsp_tvalid && rsp_tuser != KIND_SAMPLE |-> rsp_tdata[79:16] == 64'd0,
      "I/Q nonzero outside a sample word")

   // rejected packets report sequence zero
   `IQDF_ASSERT(a_reject_seq,
      rsp_tvalid && rsp_tuser == KIND_REJECT |-> rsp_tdata[15:0] == 16'd0,
      "reject word with nonzero sequence")

   // nothing is presented right after reset
   `IQDF_ASSERT_ALWAYS(a_reset_idle, $past(reset) && !reset |-> !rsp_tvalid,
      "result valid right after reset")

endmodule

bind iq_packet_deframer_seq_check iqdf_checker u_iqdf_checker (.*);
